FILE: design/aik_pkg.sv
package aik_pkg;

    // datapath widths shared by the arithmetic units
    localparam int AT_W     = 34;
    localparam int ANG_W    = 25;
    localparam int SQ_IN_W  = 60;
    localparam int SQ_OUT_W = 30;
    localparam int SQ_LAT   = 30;
    localparam int NORM_N   = 5;
    localparam int CORDIC_N = 17;
    localparam int AT_LAT   = 1 + NORM_N + CORDIC_N + 1;
    localparam int DEG_Q    = 65536;

    localparam logic signed [ANG_W-1:0] ANG_45  = ANG_W'(45 * DEG_Q);
    localparam logic signed [ANG_W-1:0] ANG_65  = ANG_W'(65 * DEG_Q);
    localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 * DEG_Q);
    localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * DEG_Q);

    // arctangent of 2^-i in degrees, 16 fraction bits
    localparam logic signed [23:0] ATAN_TAB [CORDIC_N] = '{
        24'sd2949120, 24'sd1740967, 24'sd919879, 24'sd466945, 24'sd234379,
        24'sd117304, 24'sd58666, 24'sd29335, 24'sd14668, 24'sd7334,
        24'sd3667, 24'sd1833, 24'sd917, 24'sd458, 24'sd229, 24'sd115, 24'sd57
    };

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_BASE_HEIGHT = 2'd0,
        REG_UPPER_LINK  = 2'd1,
        REG_LOWER_LINK  = 2'd2
    } cfg_reg_t;

endpackage

FILE: design/aik_isqrt.sv
module aik_isqrt (
    input  logic                          clk,
    input  logic [aik_pkg::SQ_IN_W-1:0]   radicand,
    output logic [aik_pkg::SQ_OUT_W-1:0]  root
);
    import aik_pkg::*;

    localparam int REM_W = SQ_OUT_W + 4;

    logic [SQ_IN_W-1:0]  rad_reg  [SQ_LAT];
    logic [REM_W-1:0]    rem_reg  [SQ_LAT];
    logic [SQ_OUT_W-1:0] root_reg [SQ_LAT];

    // one root bit per stage, restoring digit recurrence
    for (genvar k = 0; k < SQ_LAT; k++)
    begin : g_step
        logic [SQ_IN_W-1:0]  rad_in;
        logic [REM_W-1:0]    rem_in;
        logic [SQ_OUT_W-1:0] root_in;
        logic [REM_W-1:0]    cur;
        logic [REM_W-1:0]    trial;

        if (k == 0)
        begin : g_first
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        always_comb
        begin
            cur   = {rem_in[REM_W-3:0], rad_in[SQ_IN_W-1 -: 2]};
            trial = REM_W'({root_in, 2'b01});
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k] <= rad_in << 2;
            if (cur >= trial)
            begin
                rem_reg[k]  <= cur - trial;
                root_reg[k] <= {root_in[SQ_OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k]  <= cur;
                root_reg[k] <= {root_in[SQ_OUT_W-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg[SQ_LAT-1];

endmodule

FILE: design/aik_atan2.sv
module aik_atan2 (
    input  logic                              clk,
    input  logic signed [aik_pkg::AT_W-1:0]   y_in,
    input  logic signed [aik_pkg::AT_W-1:0]   x_in,
    output logic signed [aik_pkg::ANG_W-1:0]  angle
);
    import aik_pkg::*;

    localparam int CW = AT_W + 2;
    localparam int ZW = 24;
    localparam logic signed [ZW-1:0] Z_MAX = ZW'(45 * DEG_Q - 1);

    typedef struct packed {
        logic                    xneg;
        logic                    yneg;
        logic                    use_fix;
        logic                    swap;
        logic signed [ANG_W-1:0] fix;
    } oct_t;

    logic [AT_W-1:0] ax;
    logic [AT_W-1:0] ay;
    logic [AT_W-1:0] fa;
    logic [AT_W-1:0] fb;
    oct_t            foct;

    logic [AT_W-1:0] fa_reg;
    logic [AT_W-1:0] fb_reg;
    oct_t            foct_reg;

    logic [AT_W-1:0] na_reg   [NORM_N];
    logic [AT_W-1:0] nb_reg   [NORM_N];
    oct_t            noct_reg [NORM_N];

    logic signed [CW-1:0] cx_reg   [CORDIC_N];
    logic signed [CW-1:0] cy_reg   [CORDIC_N];
    logic signed [ZW-1:0] cz_reg   [CORDIC_N];
    oct_t                 coct_reg [CORDIC_N];

    logic signed [ANG_W-1:0] angle_reg;
    logic signed [ANG_W-1:0] angle_next;

    // fold into the first octant, catch axes and the diagonal
    always_comb
    begin
        ax           = x_in[AT_W-1] ? AT_W'(-x_in) : AT_W'(x_in);
        ay           = y_in[AT_W-1] ? AT_W'(-y_in) : AT_W'(y_in);
        fa           = ax;
        fb           = ay;
        foct.xneg    = x_in[AT_W-1];
        foct.yneg    = y_in[AT_W-1];
        foct.use_fix = 1'b1;
        foct.swap    = 1'b0;
        foct.fix     = '0;
        priority if (ax == '0 && ay == '0)
        begin
            foct.fix = '0;
        end
        else if (ax == '0)
        begin
            foct.fix = ANG_90;
        end
        else if (ay == '0)
        begin
            foct.fix = '0;
        end
        else if (ay == ax)
        begin
            foct.fix = ANG_45;
        end
        else
        begin
            foct.use_fix = 1'b0;
            if (ay > ax)
            begin
                foct.swap = 1'b1;
                fa        = ay;
                fb        = ax;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fa_reg   <= fa;
        fb_reg   <= fb;
        foct_reg <= foct;
    end

    // normalise the larger side to at least 2^30, binary shift steps
    for (genvar n = 0; n < NORM_N; n++)
    begin : g_norm
        localparam int STEP = 1 << (NORM_N - 1 - n);
        logic [AT_W-1:0] a_in;
        logic [AT_W-1:0] b_in;
        oct_t            o_in;

        if (n == 0)
        begin : g_first
            assign a_in = fa_reg;
            assign b_in = fb_reg;
            assign o_in = foct_reg;
        end
        else
        begin : g_next
            assign a_in = na_reg[n-1];
            assign b_in = nb_reg[n-1];
            assign o_in = noct_reg[n-1];
        end

        always_ff @(posedge clk)
        begin
            noct_reg[n] <= o_in;
            if (a_in < (AT_W'(1) << (31 - STEP)))
            begin
                na_reg[n] <= a_in << STEP;
                nb_reg[n] <= b_in << STEP;
            end
            else
            begin
                na_reg[n] <= a_in;
                nb_reg[n] <= b_in;
            end
        end
    end

    // vectoring iterations, one per stage
    for (genvar i = 0; i < CORDIC_N; i++)
    begin : g_rot
        logic signed [CW-1:0] x_src;
        logic signed [CW-1:0] y_src;
        logic signed [ZW-1:0] z_src;
        oct_t                 o_src;

        if (i == 0)
        begin : g_first
            assign x_src = signed'({2'b00, na_reg[NORM_N-1]});
            assign y_src = signed'({2'b00, nb_reg[NORM_N-1]});
            assign z_src = '0;
            assign o_src = noct_reg[NORM_N-1];
        end
        else
        begin : g_next
            assign x_src = cx_reg[i-1];
            assign y_src = cy_reg[i-1];
            assign z_src = cz_reg[i-1];
            assign o_src = coct_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            coct_reg[i] <= o_src;
            if (!y_src[CW-1])
            begin
                cx_reg[i] <= x_src + (y_src >>> i);
                cy_reg[i] <= y_src - (x_src >>> i);
                cz_reg[i] <= z_src + ATAN_TAB[i];
            end
            else
            begin
                cx_reg[i] <= x_src - (y_src >>> i);
                cy_reg[i] <= y_src + (x_src >>> i);
                cz_reg[i] <= z_src - ATAN_TAB[i];
            end
        end
    end

    // clamp, then unfold back to the full circle
    always_comb
    begin
        logic signed [ZW-1:0]    zc;
        logic signed [ANG_W-1:0] t0;
        logic signed [ANG_W-1:0] t1;
        oct_t                    o;

        o = coct_reg[CORDIC_N-1];
        if (cz_reg[CORDIC_N-1] < 0)
        begin
            zc = '0;
        end
        else if (cz_reg[CORDIC_N-1] > Z_MAX)
        begin
            zc = Z_MAX;
        end
        else
        begin
            zc = cz_reg[CORDIC_N-1];
        end

        if (o.use_fix)
        begin
            t0 = o.fix;
        end
        else if (o.swap)
        begin
            t0 = ANG_90 - ANG_W'(zc);
        end
        else
        begin
            t0 = ANG_W'(zc);
        end

        t1         = o.xneg ? ANG_180 - t0 : t0;
        angle_next = o.yneg ? -t1 : t1;
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

FILE: design/arm_inverse_kinematics.sv
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+------------------------------
// target    | target_x, target_y, target_z                 | beat on start && !busy
// config    | cfg_index, cfg_data                          | beat on cfg_valid && cfg_ready
// result    | base_pulse_us, shoulder_deg16, wrist_deg16,  | beat on done, one cycle
//           | unreachable                                  |
//
// one target per cycle; each result comes out with done once its start beat has passed
// through the front end, the square roots, the arc tangents and the output stages
// most of the latency comes from the 30-stage square roots and the 24-stage cordic arc tangents
// busy stays low and cfg_ready stays high; there is no stall on either side
// rst_n clears the valid pipe, loads the base height with 100 and the two link registers with 150
module arm_inverse_kinematics #(
    parameter int ANGLE_FRAC_BITS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic signed [15:0] target_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    output logic               done,
    output logic [11:0]        base_pulse_us,
    output logic signed [13:0] shoulder_deg16,
    output logic signed [12:0] wrist_deg16,
    output logic               unreachable
);
    import aik_pkg::*;

    localparam int PIPE_LAT = 8 + SQ_LAT + AT_LAT + 2;
    localparam int RSH      = 16 - ANGLE_FRAC_BITS;
    localparam logic signed [25:0] RND = 26'sd1 <<< (RSH - 1);

    typedef struct packed {
        logic signed [33:0] n;
        logic signed [33:0] m;
        logic signed [16:0] zo;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               unreach;
    } side_t;

    typedef struct packed {
        logic zo_pos;
        logic unreach;
    } tail_t;

    logic [11:0] base_height_reg;
    logic [11:0] upper_link_reg;
    logic [11:0] lower_link_reg;

    logic [PIPE_LAT-1:0] vld_reg;

    // stage 1
    logic signed [15:0] x1_reg, y1_reg, z1_reg;
    logic [11:0]        l0_1_reg, l1_1_reg, l2_1_reg;
    // stage 2
    logic [30:0]        xx2_reg, yy2_reg;
    logic signed [16:0] zo2_reg;
    logic [23:0]        l1sq2_reg, l2sq2_reg, l1l2_2_reg;
    logic signed [15:0] x2_reg, y2_reg;
    logic               zero2_reg;
    // stage 3
    logic [31:0]        s3_reg;
    logic [30:0]        zosq3_reg;
    logic signed [16:0] zo3_reg;
    logic [23:0]        l1sq3_reg, l2sq3_reg;
    logic [24:0]        limb3_reg;
    logic signed [15:0] x3_reg, y3_reg;
    logic               zero3_reg;
    // stage 4
    logic [31:0]        r2_4_reg, s4_reg;
    logic signed [16:0] zo4_reg;
    logic [23:0]        l1sq4_reg, l2sq4_reg;
    logic [24:0]        limb4_reg;
    logic signed [15:0] x4_reg, y4_reg;
    logic               zero4_reg;
    // stage 5
    logic signed [33:0] n5_reg, m5_reg;
    logic [55:0]        limtp5_reg;
    logic               zero5_reg;
    logic [24:0]        limb5_reg;
    logic [31:0]        s5_reg;
    logic signed [16:0] zo5_reg;
    logic signed [15:0] x5_reg, y5_reg;
    // stage 6
    logic [32:0]        an6_reg, am6_reg;
    logic               bigt6_reg, bigb6_reg, zero6_reg;
    logic [57:0]        limt6_reg;
    logic [24:0]        limb6_reg;
    logic signed [33:0] n6_reg, m6_reg;
    logic [31:0]        s6_reg;
    logic signed [16:0] zo6_reg;
    logic signed [15:0] x6_reg, y6_reg;
    // stage 7
    logic [57:0]        an2_7_reg, limt7_reg;
    logic [49:0]        am2_7_reg, lb2_7_reg;
    logic               unr7_reg;
    logic signed [33:0] n7_reg, m7_reg;
    logic [31:0]        s7_reg;
    logic signed [16:0] zo7_reg;
    logic signed [15:0] x7_reg, y7_reg;
    // stage 8
    logic [57:0]        radt8_reg;
    logic [49:0]        radb8_reg;
    side_t              side8_reg;
    logic [31:0]        s8_reg;

    side_t side_reg [SQ_LAT];
    tail_t tail_reg [AT_LAT];

    logic [SQ_OUT_W-1:0]     sqt, sqb, sqp;
    logic signed [ANG_W-1:0] theta, beta, phi, head;

    // final stages
    logic [8:0]         w_reg;
    logic signed [25:0] sh1_reg, wr1_reg;
    logic               unr1_reg;
    logic [11:0]        pulse_reg;
    logic signed [13:0] sh_out_reg;
    logic signed [12:0] wr_out_reg;
    logic               unr_out_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_height_reg <= 12'd100;
            upper_link_reg  <= 12'd150;
            lower_link_reg  <= 12'd150;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BASE_HEIGHT: base_height_reg <= cfg_data;
                REG_UPPER_LINK:  upper_link_reg  <= cfg_data;
                REG_LOWER_LINK:  lower_link_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], start};
        end
    end

    // front end: squares, sums, law of cosines terms and range tests
    always_ff @(posedge clk)
    begin
        x1_reg   <= target_x;
        y1_reg   <= target_y;
        z1_reg   <= target_z;
        l0_1_reg <= base_height_reg;
        l1_1_reg <= upper_link_reg;
        l2_1_reg <= lower_link_reg;

        xx2_reg    <= 31'(32'(x1_reg * x1_reg));
        yy2_reg    <= 31'(32'(y1_reg * y1_reg));
        zo2_reg    <= 17'(signed'({z1_reg[15], z1_reg}) - signed'({5'b0, l0_1_reg}));
        l1sq2_reg  <= l1_1_reg * l1_1_reg;
        l2sq2_reg  <= l2_1_reg * l2_1_reg;
        l1l2_2_reg <= l1_1_reg * l2_1_reg;
        x2_reg     <= x1_reg;
        y2_reg     <= y1_reg;
        zero2_reg  <= (l1_1_reg == '0) || (l2_1_reg == '0);

        s3_reg    <= 32'(xx2_reg) + 32'(yy2_reg);
        zosq3_reg <= 31'(34'(zo2_reg * zo2_reg));
        zo3_reg   <= zo2_reg;
        l1sq3_reg <= l1sq2_reg;
        l2sq3_reg <= l2sq2_reg;
        limb3_reg <= {l1l2_2_reg, 1'b0};
        x3_reg    <= x2_reg;
        y3_reg    <= y2_reg;
        zero3_reg <= zero2_reg;

        r2_4_reg  <= s3_reg + 32'(zosq3_reg);
        s4_reg    <= s3_reg;
        zo4_reg   <= zo3_reg;
        l1sq4_reg <= l1sq3_reg;
        l2sq4_reg <= l2sq3_reg;
        limb4_reg <= limb3_reg;
        x4_reg    <= x3_reg;
        y4_reg    <= y3_reg;
        zero4_reg <= zero3_reg;

        n5_reg     <= signed'(34'(r2_4_reg) + 34'(l1sq4_reg) - 34'(l2sq4_reg));
        m5_reg     <= signed'(34'(l1sq4_reg) + 34'(l2sq4_reg) - 34'(r2_4_reg));
        limtp5_reg <= r2_4_reg * l1sq4_reg;
        zero5_reg  <= zero4_reg || (r2_4_reg == '0);
        limb5_reg  <= limb4_reg;
        s5_reg     <= s4_reg;
        zo5_reg    <= zo4_reg;
        x5_reg     <= x4_reg;
        y5_reg     <= y4_reg;
    end

    always_ff @(posedge clk)
    begin
        logic [32:0] an;
        logic [32:0] am;

        an = n5_reg[33] ? 33'(-n5_reg) : 33'(n5_reg);
        am = m5_reg[33] ? 33'(-m5_reg) : 33'(m5_reg);

        an6_reg   <= an;
        am6_reg   <= am;
        bigt6_reg <= |an[32:29];
        bigb6_reg <= am > 33'(limb5_reg);
        zero6_reg <= zero5_reg;
        limt6_reg <= {limtp5_reg, 2'b00};
        limb6_reg <= limb5_reg;
        n6_reg    <= n5_reg;
        m6_reg    <= m5_reg;
        s6_reg    <= s5_reg;
        zo6_reg   <= zo5_reg;
        x6_reg    <= x5_reg;
        y6_reg    <= y5_reg;

        an2_7_reg <= an6_reg[28:0] * an6_reg[28:0];
        am2_7_reg <= am6_reg[24:0] * am6_reg[24:0];
        lb2_7_reg <= limb6_reg * limb6_reg;
        limt7_reg <= limt6_reg;
        unr7_reg  <= zero6_reg || bigt6_reg || bigb6_reg;
        n7_reg    <= n6_reg;
        m7_reg    <= m6_reg;
        s7_reg    <= s6_reg;
        zo7_reg   <= zo6_reg;
        x7_reg    <= x6_reg;
        y7_reg    <= y6_reg;

        radt8_reg         <= limt7_reg - an2_7_reg;
        radb8_reg         <= lb2_7_reg - am2_7_reg;
        side8_reg.unreach <= unr7_reg || (an2_7_reg > limt7_reg);
        side8_reg.n       <= n7_reg;
        side8_reg.m       <= m7_reg;
        side8_reg.zo      <= zo7_reg;
        side8_reg.x       <= x7_reg;
        side8_reg.y       <= y7_reg;
        s8_reg            <= s7_reg;
    end

    // square roots for the two sines and the planar radius
    aik_isqrt u_sqrt_theta (
        .clk      (clk),
        .radicand ({2'b00, radt8_reg}),
        .root     (sqt)
    );

    aik_isqrt u_sqrt_beta (
        .clk      (clk),
        .radicand ({10'b0, radb8_reg}),
        .root     (sqb)
    );

    aik_isqrt u_sqrt_radius (
        .clk      (clk),
        .radicand ({s8_reg, 28'b0}),
        .root     (sqp)
    );

    // side data delayed to meet the roots
    always_ff @(posedge clk)
    begin
        side_reg[0] <= side8_reg;
        for (int k = 1; k < SQ_LAT; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // arc tangents
    aik_atan2 u_atan_theta (
        .clk   (clk),
        .y_in  (signed'(AT_W'(sqt))),
        .x_in  (side_reg[SQ_LAT-1].n),
        .angle (theta)
    );

    aik_atan2 u_atan_beta (
        .clk   (clk),
        .y_in  (signed'(AT_W'(sqb))),
        .x_in  (side_reg[SQ_LAT-1].m),
        .angle (beta)
    );

    aik_atan2 u_atan_phi (
        .clk   (clk),
        .y_in  ({{3{side_reg[SQ_LAT-1].zo[16]}}, side_reg[SQ_LAT-1].zo, 14'b0}),
        .x_in  (signed'(AT_W'(sqp))),
        .angle (phi)
    );

    aik_atan2 u_atan_head (
        .clk   (clk),
        .y_in  ({{18{side_reg[SQ_LAT-1].y[15]}}, side_reg[SQ_LAT-1].y}),
        .x_in  ({{18{side_reg[SQ_LAT-1].x[15]}}, side_reg[SQ_LAT-1].x}),
        .angle (head)
    );

    always_ff @(posedge clk)
    begin
        tail_reg[0].zo_pos  <= !side_reg[SQ_LAT-1].zo[16] && (side_reg[SQ_LAT-1].zo != '0);
        tail_reg[0].unreach <= side_reg[SQ_LAT-1].unreach;
        for (int k = 1; k < AT_LAT; k++)
        begin
            tail_reg[k] <= tail_reg[k-1];
        end
    end

    // joint angles in degrees with 16 fraction bits, base heading in whole degrees
    always_ff @(posedge clk)
    begin
        logic [ANG_W-1:0] hmag;
        logic [8:0]       dm;

        hmag = head[ANG_W-1] ? ANG_W'(-head) : ANG_W'(head);
        dm   = hmag[ANG_W-1:16];
        if (head[ANG_W-1] && dm != '0)
        begin
            w_reg <= 9'd360 - dm;
        end
        else
        begin
            w_reg <= dm;
        end

        if (tail_reg[AT_LAT-1].zo_pos)
        begin
            sh1_reg <= 26'({phi[ANG_W-1:16], 16'b0}) + 26'(theta) + 26'(ANG_90);
            wr1_reg <= 26'(beta) - 26'(ANG_65);
        end
        else
        begin
            sh1_reg <= 26'(theta) - 26'(phi);
            wr1_reg <= 26'(beta);
        end
        unr1_reg <= tail_reg[AT_LAT-1].unreach;
    end

    // pulse width and rounding to the output format
    always_ff @(posedge clk)
    begin
        logic [26:0]        pm;
        logic signed [25:0] shr;
        logic signed [25:0] wrr;

        pm        = (w_reg + 9'd70) * 18'd182050;
        pulse_reg <= pm[26:15];

        shr = (sh1_reg + RND) >>> RSH;
        wrr = (wr1_reg + RND) >>> RSH;

        if (unr1_reg)
        begin
            sh_out_reg <= '0;
        end
        else if (shr > 26'sd8191)
        begin
            sh_out_reg <= 14'sd8191;
        end
        else if (shr < -26'sd8192)
        begin
            sh_out_reg <= -14'sd8192;
        end
        else
        begin
            sh_out_reg <= shr[13:0];
        end

        if (unr1_reg)
        begin
            wr_out_reg <= '0;
        end
        else if (wrr > 26'sd4095)
        begin
            wr_out_reg <= 13'sd4095;
        end
        else if (wrr < -26'sd4096)
        begin
            wr_out_reg <= -13'sd4096;
        end
        else
        begin
            wr_out_reg <= wrr[12:0];
        end

        unr_out_reg <= unr1_reg;
    end

    assign done           = vld_reg[PIPE_LAT-1];
    assign base_pulse_us  = pulse_reg;
    assign shoulder_deg16 = sh_out_reg;
    assign wrist_deg16    = wr_out_reg;
    assign unreachable    = unr_out_reg;

endmodule
